### rtl/ict_pkg.sv
package ict_pkg;

    localparam int DATA_W    = 32;
    localparam int DVS_W     = 12;
    localparam int NUM_LANES = 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int LATENCY   = 2 * (DIV_STEPS + 2) + 6;

    localparam logic [1:0] FUNC_TILE      = 2'd0;
    localparam logic [1:0] FUNC_RAW       = 2'd1;
    localparam logic [1:0] FUNC_TO_SCREEN = 2'd2;
    localparam logic [1:0] FUNC_SNAP      = 2'd3;

    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_PAN_X    = 3'd2;
    localparam logic [2:0] REG_PAN_Y    = 3'd3;
    localparam logic [2:0] REG_TILE_W   = 3'd4;
    localparam logic [2:0] REG_TILE_H   = 3'd5;
    localparam logic [2:0] REG_GRID     = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DVS_W-1:0]  rem;
        logic              neg;
    } div_lane_t;

    typedef struct packed {
        logic [DVS_W-1:0] mag;
        logic             neg;
        logic             zero;
    } divisor_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } side_t;

    function automatic divisor_t make_divisor(input logic signed [DVS_W-1:0] d);
        divisor_t r;
        r.neg  = d[DVS_W-1];
        r.mag  = d[DVS_W-1] ? DVS_W'(-d) : DVS_W'(d);
        r.zero = (d == '0);
        return r;
    endfunction

endpackage

### rtl/ict_div_cell.sv
module ict_div_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  ict_pkg::div_lane_t [1:0]          in_lane,
    input  ict_pkg::side_t                    in_side,
    input  ict_pkg::divisor_t [1:0]           dvs,
    output logic                              out_valid,
    output ict_pkg::div_lane_t [1:0]          out_lane,
    output ict_pkg::side_t                    out_side
);
    import ict_pkg::*;

    logic                 valid_reg;
    div_lane_t [1:0]      lane_reg;
    div_lane_t [1:0]      lane_next;
    side_t                side_reg;
    logic [DVS_W:0]       shifted [NUM_LANES];
    logic [DVS_W:0]       diff [NUM_LANES];

    // One restoring step per lane: bring down the next dividend bit and try the divisor.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            shifted[i] = {in_lane[i].rem, in_lane[i].acc[DATA_W-1]};
            diff[i] = shifted[i] - {1'b0, dvs[i].mag};
            lane_next[i].neg = in_lane[i].neg;
            if (!diff[i][DVS_W])
            begin
                lane_next[i].rem = diff[i][DVS_W-1:0];
                lane_next[i].acc = {in_lane[i].acc[DATA_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[i].rem = shifted[i][DVS_W-1:0];
                lane_next[i].acc = {in_lane[i].acc[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule

### rtl/ict_div_chain.sv
module ict_div_chain (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [1:0][ict_pkg::DATA_W-1:0]        in_num,
    input  ict_pkg::side_t                         in_side,
    input  ict_pkg::divisor_t [1:0]                dvs,
    output logic                                   out_valid,
    output logic [1:0][ict_pkg::DATA_W-1:0]        out_quo,
    output ict_pkg::side_t                         out_side
);
    import ict_pkg::*;

    logic                 v_w [DIV_STEPS+1];
    div_lane_t [1:0]      lane_w [DIV_STEPS+1];
    side_t                side_w [DIV_STEPS+1];
    logic                 in_v_reg;
    div_lane_t [1:0]      in_lane_reg;
    side_t                in_side_reg;
    logic                 out_v_reg;
    logic [1:0][DATA_W-1:0] quo_reg;
    side_t                out_side_reg;

    // The dividend magnitude enters here; the sign of the quotient rides along.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_valid;
            out_v_reg <= v_w[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            in_lane_reg[i].acc <= in_num[i][DATA_W-1] ? (-in_num[i]) : in_num[i];
            in_lane_reg[i].rem <= '0;
            in_lane_reg[i].neg <= in_num[i][DATA_W-1] ^ dvs[i].neg;
            if (dvs[i].zero)
            begin
                quo_reg[i] <= '0;
            end
            else if (lane_w[DIV_STEPS][i].neg)
            begin
                quo_reg[i] <= -lane_w[DIV_STEPS][i].acc;
            end
            else
            begin
                quo_reg[i] <= lane_w[DIV_STEPS][i].acc;
            end
        end
        in_side_reg  <= in_side;
        out_side_reg <= side_w[DIV_STEPS];
    end

    assign v_w[0]    = in_v_reg;
    assign lane_w[0] = in_lane_reg;
    assign side_w[0] = in_side_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        ict_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_w[k]),
            .in_lane   (lane_w[k]),
            .in_side   (side_w[k]),
            .dvs       (dvs),
            .out_valid (v_w[k+1]),
            .out_lane  (lane_w[k+1]),
            .out_side  (side_w[k+1])
        );
    end

    assign out_valid = out_v_reg;
    assign out_quo   = quo_reg;
    assign out_side  = out_side_reg;

    a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, DIV_STEPS + 2))
        else $error("Quotient word left the divider chain at the wrong time.");

endmodule

### rtl/isometric_cartesian_transform.sv
// Isometric screen to cartesian tile converter.
// A word is accepted at a rising edge with start high and busy low; busy is
// always low, so one point can be accepted in every cycle. func selects
// screen to tile, screen to raw, tile to screen or snap, and point_x and
// point_y carry the point.
// The result appears on out_x and out_y after the input stages, both divider chains and the output stages, for
// exactly one cycle with done high, in the order the words were accepted.
// The latency is set by two chains of 32 one-bit restoring divider cells
// in series, plus the address arithmetic and multiplier stages around them.
// Throughput is one point per cycle whatever func is.
// The configuration channel takes a register index and data when cfg_valid
// is high; cfg_ready is always high. Registers may only be written while no
// point is in flight.
// Reset clears the pipeline and loads the default screen, pan, tile and
// grid settings. The receiver cannot stall the results.
module isometric_cartesian_transform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic signed [15:0]  point_x,
    input  logic signed [15:0]  point_y,
    output logic                done,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import ict_pkg::*;

    logic [13:0]        sw_reg;
    logic [13:0]        sh_reg;
    logic signed [15:0] pan_x_reg;
    logic signed [15:0] pan_y_reg;
    logic [8:0]         tw_reg;
    logic [8:0]         th_reg;
    logic [10:0]        grid_reg;

    logic signed [9:0]  w_s;
    logic signed [9:0]  h_s;
    logic [8:0]         hw;
    logic [8:0]         hh;
    logic signed [19:0] wh_reg;
    logic signed [31:0] whg_reg;
    logic [19:0]        hwg_reg;
    divisor_t [1:0]     dvs1_reg;
    divisor_t [1:0]     dvs2_reg;

    logic               accept;
    logic               s0_v_reg;
    logic [1:0]         s0_func_reg;
    logic signed [15:0] s0_px_reg;
    logic signed [15:0] s0_py_reg;
    logic signed [17:0] x_s;
    logic signed [17:0] y_s;
    logic               s1_v_reg;
    logic [1:0]         s1_func_reg;
    logic signed [15:0] s1_px_reg;
    logic signed [15:0] s1_py_reg;
    logic signed [27:0] s1_p1_reg;
    logic signed [27:0] s1_p2_reg;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic               s2_v_reg;
    logic [1:0][DATA_W-1:0] s2_n_reg;
    side_t              s2_side_reg;

    logic               c1_v;
    logic [1:0][DATA_W-1:0] c1_q;
    side_t              c1_side;
    side_t              c2_in_side;
    logic [1:0][DATA_W-1:0] c2_in_num;
    logic               c2_v;
    logic [1:0][DATA_W-1:0] c2_q;
    side_t              c2_side;

    logic [31:0]        tx;
    logic [31:0]        ty;
    logic               t1_v_reg;
    logic [1:0]         t1_func_reg;
    logic [31:0]        t1_a_reg;
    logic [31:0]        t1_b_reg;
    logic [31:0]        t1_sum_reg;
    logic [31:0]        t1_dif_reg;
    logic               t2_v_reg;
    logic [1:0]         t2_func_reg;
    logic [31:0]        t2_a_reg;
    logic [31:0]        t2_b_reg;
    logic [31:0]        t2_xx_reg;
    logic [31:0]        t2_yy_reg;
    logic [31:0]        sx;
    logic [31:0]        sy;
    logic               done_reg;
    logic [31:0]        out_x_reg;
    logic [31:0]        out_y_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= 14'd1024;
            sh_reg    <= 14'd768;
            pan_x_reg <= '0;
            pan_y_reg <= '0;
            tw_reg    <= 9'd64;
            th_reg    <= 9'd32;
            grid_reg  <= 11'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_W: sw_reg    <= cfg_data[13:0];
                REG_SCREEN_H: sh_reg    <= cfg_data[13:0];
                REG_PAN_X:    pan_x_reg <= cfg_data;
                REG_PAN_Y:    pan_y_reg <= cfg_data;
                REG_TILE_W:   tw_reg    <= cfg_data[8:0];
                REG_TILE_H:   th_reg    <= cfg_data[8:0];
                REG_GRID:     grid_reg  <= cfg_data[10:0];
                default:      ;
            endcase
        end
    end

    // Terms that depend on the configuration alone.
    assign w_s = $signed({1'b0, tw_reg}) - 10'sd1;
    assign h_s = $signed({1'b0, th_reg}) - 10'sd1;
    assign hw  = w_s[9] ? 9'd0 : w_s[9:1];
    assign hh  = h_s[9] ? 9'd0 : h_s[9:1];

    always_ff @(posedge clk)
    begin
        wh_reg      <= 20'(w_s) * 20'(h_s);
        whg_reg     <= 32'(wh_reg) * 32'($signed({1'b0, grid_reg}));
        hwg_reg     <= 20'(hw) * 20'(grid_reg);
        dvs1_reg[0] <= make_divisor({w_s[9], w_s, 1'b0});
        dvs1_reg[1] <= make_divisor({h_s, 2'b00});
        dvs2_reg[0] <= make_divisor({{2{h_s[9]}}, h_s});
        dvs2_reg[1] <= make_divisor({{2{w_s[9]}}, w_s});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= accept;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            t1_v_reg <= c2_v;
            t2_v_reg <= t1_v_reg;
            done_reg <= t2_v_reg;
        end
    end

    assign x_s = 18'(s0_px_reg) - $signed({5'b0, sw_reg[13:1]}) + 18'(pan_x_reg);
    assign y_s = $signed({5'b0, sh_reg[13:1]}) - 18'(s0_py_reg) - 18'(pan_y_reg);
    assign rx  = 32'(s1_p1_reg) + 32'(s1_p2_reg);
    assign ry  = 32'(s1_p2_reg) - 32'(s1_p1_reg);

    always_ff @(posedge clk)
    begin
        s0_func_reg      <= func;
        s0_px_reg        <= point_x;
        s0_py_reg        <= point_y;
        s1_func_reg      <= s0_func_reg;
        s1_px_reg        <= s0_px_reg;
        s1_py_reg        <= s0_py_reg;
        s1_p1_reg        <= 28'(x_s) * 28'(h_s);
        s1_p2_reg        <= 28'(y_s) * 28'(w_s);
        s2_n_reg[0]      <= {rx[30:0], 1'b0} + whg_reg;
        s2_n_reg[1]      <= whg_reg - {ry[30:0], 1'b0};
        s2_side_reg.func <= s1_func_reg;
        s2_side_reg.a    <= 32'(s1_px_reg);
        s2_side_reg.b    <= 32'(s1_py_reg);
    end

    ict_div_chain u_raw_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg),
        .in_num    (s2_n_reg),
        .in_side   (s2_side_reg),
        .dvs       (dvs1_reg),
        .out_valid (c1_v),
        .out_quo   (c1_q),
        .out_side  (c1_side)
    );

    // The raw result is kept in the side word; a tile point passes on untouched.
    always_comb
    begin
        c2_in_side = c1_side;
        if (c1_side.func == FUNC_RAW)
        begin
            c2_in_side.a = c1_q[0];
            c2_in_side.b = c1_q[1];
        end
        c2_in_num[0] = c1_q[0];
        c2_in_num[1] = {c1_q[1][DATA_W-2:0], 1'b0};
    end

    ict_div_chain u_tile_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_v),
        .in_num    (c2_in_num),
        .in_side   (c2_in_side),
        .dvs       (dvs2_reg),
        .out_valid (c2_v),
        .out_quo   (c2_q),
        .out_side  (c2_side)
    );

    assign tx = (c2_side.func == FUNC_TO_SCREEN) ? c2_side.a : c2_q[0];
    assign ty = (c2_side.func == FUNC_TO_SCREEN) ? c2_side.b : c2_q[1];
    assign sx = t2_xx_reg + 32'(sw_reg[13:1]) - 32'(hwg_reg) - 32'(pan_x_reg);
    assign sy = t2_yy_reg + 32'(sh_reg[13:1]) - 32'(hh) - 32'(pan_y_reg);

    always_ff @(posedge clk)
    begin
        t1_func_reg <= c2_side.func;
        t1_a_reg    <= (c2_side.func == FUNC_TILE) ? c2_q[0] : c2_side.a;
        t1_b_reg    <= (c2_side.func == FUNC_TILE) ? c2_q[1] : c2_side.b;
        t1_sum_reg  <= ty + tx;
        t1_dif_reg  <= ty - tx;
        t2_func_reg <= t1_func_reg;
        t2_a_reg    <= t1_a_reg;
        t2_b_reg    <= t1_b_reg;
        t2_xx_reg   <= t1_sum_reg * 32'(hw);
        t2_yy_reg   <= t1_dif_reg * 32'(hh);
        if (t2_func_reg == FUNC_TILE || t2_func_reg == FUNC_RAW)
        begin
            out_x_reg <= t2_a_reg;
            out_y_reg <= t2_b_reg;
        end
        else
        begin
            out_x_reg <= sx;
            out_y_reg <= sy;
        end
    end

    assign done  = done_reg;
    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("Result word without a matching accepted point.");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("Accepted point produced no result word.");

endmodule
